@@ rtl/ffca_pkg.sv @@
// Shared constants, types and state encoding for the contiguous frame allocator.
`timescale 1ns / 1ps

package ffca_pkg;

  // Default geometry
  localparam int NUM_FRAMES_DEF = 256;
  localparam int PAGE_BYTES_DEF = 4096;

  // Field widths
  localparam int COUNT_W    = 9;
  localparam int FRAME_CFG_W = 9;
  localparam int ADDR_W     = 20;

  // Register port
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam logic REG_FIRST_USABLE = 1'b0;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_MARK,
    ST_RESP
  } state_t;

  // Result of one request
  typedef struct packed {
    logic              granted;
    logic [ADDR_W-1:0] phys_address;
  } res_t;

endpackage

@@ rtl/first_fit_contiguous_frame_allocator_unit.sv @@
// Top level of the first-fit contiguous page-frame allocator.
// After reset the block sweeps its free-flag memory, one frame a cycle, while
// in_stall stays high; register writes are taken meanwhile. Each request then
// takes one transfer of in_page_count and gives one result. A refused request
// (zero count, or first usable frame beyond the array) is answered without a
// scan; otherwise the request scans from the first usable frame at one frame
// per cycle through the single read port of the free-flag memory, then clears
// the found run at one frame per cycle through its write port. The block takes
// no new request until the current one is done; a finished result waits in the
// output register.
`timescale 1ns / 1ps

module first_fit_contiguous_frame_allocator_unit #(
  parameter int NUM_FRAMES = ffca_pkg::NUM_FRAMES_DEF,
  parameter int PAGE_BYTES = ffca_pkg::PAGE_BYTES_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // Request channel
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [ffca_pkg::COUNT_W-1:0]      in_page_count,
  // Result channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_granted,
  output logic [ffca_pkg::ADDR_W-1:0]       out_phys_address,
  // Register port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [ffca_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [ffca_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [ffca_pkg::APB_DATA_W-1:0]   prdata,
  output logic                              pready
);

  logic [ffca_pkg::FRAME_CFG_W-1:0] first_usable_r, first_usable_nxt;
  logic                             out_valid_r, out_valid_nxt;
  ffca_pkg::res_t                   out_res_r;
  logic                             req_ready;
  logic                             res_valid;
  ffca_pkg::res_t                   res;
  logic                             res_load;
  logic                             reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == ffca_pkg::REG_FIRST_USABLE);

  // Register write and readback
  always_comb begin
    first_usable_nxt = first_usable_r;
    if (psel && penable && pwrite && reg_sel) begin
      first_usable_nxt = pwdata[ffca_pkg::FRAME_CFG_W-1:0];
    end
  end

  assign prdata = reg_sel ? ffca_pkg::APB_DATA_W'(first_usable_r) : '0;

  ffca_engine #(
    .NUM_FRAMES (NUM_FRAMES),
    .PAGE_BYTES (PAGE_BYTES)
  ) u_engine (
    .clk            (clk),
    .rst_n          (rst_n),
    .req_valid      (in_valid),
    .req_page_count (in_page_count),
    .first_usable   (first_usable_r),
    .req_ready      (req_ready),
    .res_valid      (res_valid),
    .res            (res),
    .res_ready      (res_load)
  );

  assign in_stall = !req_ready;

  // Load the output register when it is empty or its transfer completes
  assign res_load = res_valid && (!out_valid_r || !out_stall);

  always_comb begin
    out_valid_nxt = out_valid_r;
    priority if (res_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_usable_r <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      first_usable_r <= first_usable_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_res_r <= res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_granted      = out_res_r.granted;
  assign out_phys_address = out_res_r.phys_address;

endmodule

@@ rtl/ffca_engine.sv @@
// Scan and mark sequencer over the free-flag memory of the frame allocator.
`timescale 1ns / 1ps

module ffca_engine #(
  parameter int NUM_FRAMES = ffca_pkg::NUM_FRAMES_DEF,
  parameter int PAGE_BYTES = ffca_pkg::PAGE_BYTES_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             req_valid,
  input  logic [ffca_pkg::COUNT_W-1:0]     req_page_count,
  input  logic [ffca_pkg::FRAME_CFG_W-1:0] first_usable,
  output logic                             req_ready,
  output logic                             res_valid,
  output ffca_pkg::res_t                   res,
  input  logic                             res_ready
);

  localparam int IDX_W = $clog2(NUM_FRAMES);
  localparam int CNT_W = $clog2(NUM_FRAMES + 1);
  localparam int CMP_W = (CNT_W > ffca_pkg::FRAME_CFG_W) ? CNT_W : ffca_pkg::FRAME_CFG_W;
  localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(NUM_FRAMES - 1);
  localparam logic [CMP_W-1:0] FRAMES_CM = CMP_W'(NUM_FRAMES);

  ffca_pkg::state_t state_r, state_nxt;

  logic [CNT_W-1:0]                 scan_idx_r, scan_idx_nxt;
  logic [IDX_W-1:0]                 chk_idx_r, chk_idx_nxt;
  logic                             pend_r, pend_nxt;
  logic [CNT_W-1:0]                 run_len_r, run_len_nxt;
  logic [IDX_W-1:0]                 run_start_r, run_start_nxt;
  logic [IDX_W-1:0]                 mark_idx_r, mark_idx_nxt;
  logic [IDX_W-1:0]                 mark_end_r, mark_end_nxt;
  logic [ffca_pkg::COUNT_W-1:0]     count_r, count_nxt;
  ffca_pkg::res_t                   res_r, res_nxt;

  // Free-flag memory
  logic                             mem [NUM_FRAMES];
  logic                             rd_data_r;
  logic                             mem_we;
  logic [IDX_W-1:0]                 mem_wa;
  logic                             mem_wd;
  logic                             mem_re;

  // Shared add-and-compare unit
  logic [CNT_W-1:0]                 len_inc;
  logic                             run_hit;
  logic                             found;
  logic                             last_chk;
  logic                             issue;
  logic                             refuse;
  logic [31:0]                      prod;

  assign len_inc  = run_len_r + CNT_W'(1);
  assign run_hit  = pend_r && rd_data_r;
  assign found    = run_hit && (CMP_W'(len_inc) == CMP_W'(count_r));
  assign last_chk = pend_r && (chk_idx_r == LAST_IDX);
  assign issue    = (CMP_W'(scan_idx_r) < FRAMES_CM) && !found;
  assign refuse   = (req_page_count == '0) || (CMP_W'(first_usable) >= FRAMES_CM);
  assign prod     = 32'(run_start_r) * 32'(PAGE_BYTES);

  // Memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_data_r <= mem[scan_idx_r[IDX_W-1:0]];
    end
  end

  // Advance the sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ffca_pkg::ST_CLEAR: begin
        if (scan_idx_r[IDX_W-1:0] == LAST_IDX) begin
          state_nxt = ffca_pkg::ST_IDLE;
        end
      end
      ffca_pkg::ST_IDLE: begin
        if (req_valid) begin
          state_nxt = refuse ? ffca_pkg::ST_RESP : ffca_pkg::ST_SCAN;
        end
      end
      ffca_pkg::ST_SCAN: begin
        priority if (found) begin
          state_nxt = ffca_pkg::ST_MARK;
        end else if (last_chk) begin
          state_nxt = ffca_pkg::ST_RESP;
        end
      end
      ffca_pkg::ST_MARK: begin
        if (mark_idx_r == mark_end_r) begin
          state_nxt = ffca_pkg::ST_RESP;
        end
      end
      ffca_pkg::ST_RESP: begin
        if (res_ready) begin
          state_nxt = ffca_pkg::ST_IDLE;
        end
      end
      default: state_nxt = ffca_pkg::ST_CLEAR;
    endcase
  end

  // Drive handshake and memory controls
  always_comb begin
    req_ready = 1'b0;
    res_valid = 1'b0;
    mem_we    = 1'b0;
    mem_wa    = mark_idx_r;
    mem_wd    = 1'b0;
    mem_re    = 1'b0;
    unique case (state_r)
      ffca_pkg::ST_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = scan_idx_r[IDX_W-1:0];
        mem_wd = 1'b1;
      end
      ffca_pkg::ST_IDLE: req_ready = 1'b1;
      ffca_pkg::ST_SCAN: mem_re = issue;
      ffca_pkg::ST_MARK: mem_we = 1'b1;
      ffca_pkg::ST_RESP: res_valid = 1'b1;
      default: ;
    endcase
  end

  // Datapath next values
  always_comb begin
    scan_idx_nxt  = scan_idx_r;
    chk_idx_nxt   = chk_idx_r;
    pend_nxt      = pend_r;
    run_len_nxt   = run_len_r;
    run_start_nxt = run_start_r;
    mark_idx_nxt  = mark_idx_r;
    mark_end_nxt  = mark_end_r;
    count_nxt     = count_r;
    res_nxt       = res_r;
    unique case (state_r)
      ffca_pkg::ST_CLEAR: begin
        scan_idx_nxt = scan_idx_r + CNT_W'(1);
      end
      ffca_pkg::ST_IDLE: begin
        count_nxt    = req_page_count;
        scan_idx_nxt = CNT_W'(first_usable);
        pend_nxt     = 1'b0;
        run_len_nxt  = '0;
        res_nxt      = '0;
      end
      ffca_pkg::ST_SCAN: begin
        // Evaluate the flag read last cycle
        if (pend_r) begin
          if (rd_data_r) begin
            run_len_nxt = len_inc;
            if (run_len_r == '0) begin
              run_start_nxt = chk_idx_r;
            end
          end else begin
            run_len_nxt = '0;
          end
        end
        // Start marking from the run's first frame
        if (found) begin
          mark_idx_nxt = (run_len_r == '0) ? chk_idx_r : run_start_r;
          mark_end_nxt = chk_idx_r;
        end
        // Issue the next read
        pend_nxt = issue;
        if (issue) begin
          chk_idx_nxt  = scan_idx_r[IDX_W-1:0];
          scan_idx_nxt = scan_idx_r + CNT_W'(1);
        end
        if (last_chk && !found) begin
          res_nxt = '0;
        end
      end
      ffca_pkg::ST_MARK: begin
        mark_idx_nxt = mark_idx_r + IDX_W'(1);
        if (mark_idx_r == mark_end_r) begin
          res_nxt.granted      = 1'b1;
          res_nxt.phys_address = prod[ffca_pkg::ADDR_W-1:0];
        end
      end
      ffca_pkg::ST_RESP: ;
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ffca_pkg::ST_CLEAR;
      scan_idx_r <= '0;
      pend_r     <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      scan_idx_r <= scan_idx_nxt;
      pend_r     <= pend_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    chk_idx_r   <= chk_idx_nxt;
    run_len_r   <= run_len_nxt;
    run_start_r <= run_start_nxt;
    mark_idx_r  <= mark_idx_nxt;
    mark_end_r  <= mark_end_nxt;
    count_r     <= count_nxt;
    res_r       <= res_nxt;
  end

  assign res = res_r;

endmodule
